// ----- sv/jfps_pkg.sv -----
// ----------------------------------------------------------------------------
// jfps_pkg
// Shared types, constants and helpers of the five-point Jacobi sweep core.
// ----------------------------------------------------------------------------
package jfps_pkg;

    localparam int unsigned DEF_MAX_COLS = 8192;
    localparam int unsigned DEF_MAX_ROWS = 8192;
    localparam int unsigned FRAC_BITS    = 24;

    localparam int unsigned VAL_W   = 32;
    localparam int unsigned COORD_W = 13;
    localparam int unsigned SIZE_W  = 14;
    localparam int unsigned LIMIT_W = 31;
    localparam int unsigned CFG_W   = 31;
    localparam int unsigned IDX_W   = 2;

    localparam int unsigned SIZE_MIN   = 3;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 14'd8192;

    // 1.0e-6 in the fixed-point format, rounded to nearest
    localparam logic [LIMIT_W-1:0] LIMIT_RESET =
        31'(((64'd1 << FRAC_BITS) + 64'd500000) / 64'd1000000);

    localparam logic [LIMIT_W-1:0] ABS_MAX = {LIMIT_W{1'b1}};

    // result buffer depth and its credit counter
    localparam int unsigned FIFO_DEPTH = 8;

    typedef enum logic [IDX_W-1:0] {
        REG_GRID_ROWS      = 2'd0,
        REG_GRID_COLS      = 2'd1,
        REG_CONVERGE_LIMIT = 2'd2
    } cfg_reg_t;

    // per-cell control carried alongside the data through the pipeline
    typedef struct packed {
        logic               emit;
        logic               last_cell;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } cell_tag_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_potential;
        logic [COORD_W-1:0]      cell_row;
        logic [COORD_W-1:0]      cell_col;
        logic [LIMIT_W-1:0]      max_change;
        logic                    sweep_end;
        logic                    converged;
    } result_t;

    // clamp a grid size to [SIZE_MIN, max_v] and return its last index
    function automatic logic [31:0] size_last(logic [SIZE_W-1:0] v, int unsigned max_v);
        logic [31:0] w;
        w = {18'd0, v};
        if (w < SIZE_MIN) begin
            w = SIZE_MIN;
        end else if (w > max_v) begin
            w = max_v;
        end
        return w - 32'd1;
    endfunction

endpackage

// ----- sv/jfps_scan.sv -----
// ----------------------------------------------------------------------------
// jfps_scan
// Size and limit registers, raster counters and per-cell emission flags.
// ----------------------------------------------------------------------------
module jfps_scan import jfps_pkg::*; #(
    parameter int unsigned MAX_COLS = DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS,
    localparam int unsigned CW = $clog2(MAX_COLS),
    localparam int unsigned RW = $clog2(MAX_ROWS)
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [IDX_W-1:0]   cfg_wr_index,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    input  logic               advance,
    output logic [CW-1:0]      col_addr,
    output cell_tag_t          tag,
    output logic [LIMIT_W-1:0] limit
);

    localparam int unsigned ROW_OW = (RW > COORD_W) ? RW : COORD_W;
    localparam int unsigned COL_OW = (CW > COORD_W) ? CW : COORD_W;
    localparam logic [31:0] ROWS_LAST_RST = size_last(SIZE_RESET, MAX_ROWS);
    localparam logic [31:0] COLS_LAST_RST = size_last(SIZE_RESET, MAX_COLS);

    logic [RW-1:0]      rows_last_reg;
    logic [CW-1:0]      cols_last_reg;
    logic [LIMIT_W-1:0] limit_reg;
    logic [RW-1:0]      row_reg;
    logic [CW-1:0]      col_reg;

    logic [31:0]        size_wr;
    logic               last_col;
    logic               last_row;
    logic [ROW_OW-1:0]  row_out;
    logic [COL_OW-1:0]  col_out;

    assign size_wr  = size_last(cfg_wr_data[SIZE_W-1:0],
                                (cfg_wr_index == REG_GRID_ROWS) ? MAX_ROWS : MAX_COLS);
    assign last_col = col_reg >= cols_last_reg;
    assign last_row = row_reg >= rows_last_reg;
    assign row_out  = ROW_OW'(row_reg) - ROW_OW'(1);
    assign col_out  = COL_OW'(col_reg) - COL_OW'(1);

    always_comb begin
        tag.emit      = (row_reg >= RW'(2)) && (col_reg >= CW'(2)) &&
                        (row_reg <= rows_last_reg) && (col_reg <= cols_last_reg);
        tag.last_cell = last_row && last_col;
        tag.row       = row_out[COORD_W-1:0];
        tag.col       = col_out[COORD_W-1:0];
    end

    assign col_addr = col_reg;
    assign limit    = limit_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_last_reg <= ROWS_LAST_RST[RW-1:0];
            cols_last_reg <= COLS_LAST_RST[CW-1:0];
            limit_reg     <= LIMIT_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_GRID_ROWS:      rows_last_reg <= size_wr[RW-1:0];
                REG_GRID_COLS:      cols_last_reg <= size_wr[CW-1:0];
                REG_CONVERGE_LIMIT: limit_reg     <= cfg_wr_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the raster position, wrap at the last column and row
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else if (advance) begin
            if (last_col) begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

endmodule

// ----- sv/jfps_line_buf.sv -----
// ----------------------------------------------------------------------------
// jfps_line_buf
// Upper, middle and source line buffers with registered read data.
// ----------------------------------------------------------------------------
module jfps_line_buf import jfps_pkg::*; #(
    parameter int unsigned MAX_COLS = DEF_MAX_COLS,
    localparam int unsigned CW = $clog2(MAX_COLS)
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic [CW-1:0]           addr,
    input  logic signed [VAL_W-1:0] pin,
    input  logic signed [VAL_W-1:0] sin,
    output logic signed [VAL_W-1:0] top_q,
    output logic signed [VAL_W-1:0] mid_q,
    output logic signed [VAL_W-1:0] src_q
);

    logic signed [VAL_W-1:0] upper_mem  [MAX_COLS];
    logic signed [VAL_W-1:0] middle_mem [MAX_COLS];
    logic signed [VAL_W-1:0] source_mem [MAX_COLS];

    logic                    wb_en_reg;
    logic [CW-1:0]           wb_addr_reg;
    logic signed [VAL_W-1:0] top_q_reg;
    logic signed [VAL_W-1:0] mid_q_reg;
    logic signed [VAL_W-1:0] src_q_reg;

    // read old contents, then store the new row values at the same column
    always_ff @(posedge aclk) begin
        if (advance) begin
            top_q_reg        <= upper_mem[addr];
            mid_q_reg        <= middle_mem[addr];
            src_q_reg        <= source_mem[addr];
            middle_mem[addr] <= pin;
            source_mem[addr] <= sin;
        end
    end

    // shift the old middle row into the upper row in the cycle after the read
    always_ff @(posedge aclk) begin
        if (wb_en_reg) begin
            upper_mem[wb_addr_reg] <= mid_q_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wb_en_reg <= 1'b0;
        end else begin
            wb_en_reg <= advance;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            wb_addr_reg <= addr;
        end
    end

    assign top_q = top_q_reg;
    assign mid_q = mid_q_reg;
    assign src_q = src_q_reg;

endmodule

// ----- sv/jfps_stencil.sv -----
// ----------------------------------------------------------------------------
// jfps_stencil
// Window, five-point update, change tracking and sweep-end flags.
// ----------------------------------------------------------------------------
module jfps_stencil import jfps_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    advance,
    input  logic signed [VAL_W-1:0] pin,
    input  cell_tag_t               tag,
    input  logic signed [VAL_W-1:0] top_q,
    input  logic signed [VAL_W-1:0] mid_q,
    input  logic signed [VAL_W-1:0] src_q,
    input  logic [LIMIT_W-1:0]      limit,
    output logic                    res_valid,
    output result_t                 res
);

    localparam int unsigned SUM_W = VAL_W + 3;
    localparam int unsigned Q_W   = SUM_W - 2;
    localparam int unsigned D_W   = VAL_W + 1;
    localparam logic signed [VAL_W-1:0] POS_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] NEG_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    function automatic logic signed [SUM_W-1:0] sx_sum(logic signed [VAL_W-1:0] v);
        return {{(SUM_W-VAL_W){v[VAL_W-1]}}, v};
    endfunction

    // stage 1
    logic                    v1_reg;
    logic signed [VAL_W-1:0] pin1_reg;
    cell_tag_t               tag1_reg;
    // window: w2 top row, w4/w5 middle row, w8 bottom row
    logic signed [VAL_W-1:0] w2_reg;
    logic signed [VAL_W-1:0] w4_reg;
    logic signed [VAL_W-1:0] w5_reg;
    logic signed [VAL_W-1:0] w8_reg;
    logic signed [VAL_W-1:0] src_hold_reg;
    logic signed [SUM_W-1:0] sum_next;
    // stage 2
    logic                    v2_reg;
    logic signed [SUM_W-1:0] sum2_reg;
    logic signed [VAL_W-1:0] ctr2_reg;
    cell_tag_t               tag2_reg;
    logic signed [Q_W-1:0]   q_full;
    logic signed [VAL_W-1:0] q_sat;
    logic signed [D_W-1:0]   d_next;
    // stage 3
    logic                    v3_reg;
    logic signed [VAL_W-1:0] q3_reg;
    logic signed [D_W-1:0]   d3_reg;
    cell_tag_t               tag3_reg;
    logic [D_W-1:0]          ad_full;
    logic [LIMIT_W-1:0]      ad;
    logic [LIMIT_W-1:0]      max_next;
    logic [LIMIT_W-1:0]      rmax_reg;
    logic                    conv;

    assign sum_next = sx_sum(w2_reg) + sx_sum(w8_reg) + sx_sum(w4_reg) +
                      sx_sum(mid_q) + sx_sum(src_hold_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= advance;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            pin1_reg <= pin;
            tag1_reg <= tag;
        end
    end

    // shift the window one column per cell
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            w2_reg       <= '0;
            w4_reg       <= '0;
            w5_reg       <= '0;
            w8_reg       <= '0;
            src_hold_reg <= '0;
        end else if (v1_reg) begin
            w2_reg       <= top_q;
            w4_reg       <= w5_reg;
            w5_reg       <= mid_q;
            w8_reg       <= pin1_reg;
            src_hold_reg <= src_q;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg) begin
            sum2_reg <= sum_next;
            ctr2_reg <= w5_reg;
            tag2_reg <= tag1_reg;
        end
    end

    // floor of a quarter, saturate, difference against the old center
    assign q_full = sum2_reg[SUM_W-1:2];

    always_comb begin
        priority if (q_full[Q_W-1:VAL_W-1] == 2'b01) begin
            q_sat = POS_MAX;
        end else if (q_full[Q_W-1:VAL_W-1] == 2'b10) begin
            q_sat = NEG_MIN;
        end else begin
            q_sat = q_full[VAL_W-1:0];
        end
    end

    assign d_next = {q_sat[VAL_W-1], q_sat} - {ctr2_reg[VAL_W-1], ctr2_reg};

    always_ff @(posedge aclk) begin
        if (v2_reg) begin
            q3_reg   <= q_sat;
            d3_reg   <= d_next;
            tag3_reg <= tag2_reg;
        end
    end

    // absolute change, saturated, and the running maximum
    assign ad_full  = d3_reg[D_W-1] ? D_W'(-d3_reg) : D_W'(d3_reg);
    assign ad       = (ad_full[D_W-1:LIMIT_W] != '0) ? ABS_MAX : ad_full[LIMIT_W-1:0];
    assign max_next = (ad > rmax_reg) ? ad : rmax_reg;
    assign conv     = (ad <= limit) && (rmax_reg <= limit);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rmax_reg <= '0;
        end else if (v3_reg) begin
            if (tag3_reg.last_cell) begin
                rmax_reg <= '0;
            end else if (tag3_reg.emit) begin
                rmax_reg <= max_next;
            end
        end
    end

    assign res_valid = v3_reg && tag3_reg.emit;

    always_comb begin
        res.new_potential = q3_reg;
        res.cell_row      = tag3_reg.row;
        res.cell_col      = tag3_reg.col;
        res.max_change    = max_next;
        res.sweep_end     = tag3_reg.last_cell;
        res.converged     = tag3_reg.last_cell && conv;
    end

endmodule

// ----- sv/jfps_out_fifo.sv -----
// ----------------------------------------------------------------------------
// jfps_out_fifo
// Result buffer with a credit count that covers results still in flight.
// ----------------------------------------------------------------------------
module jfps_out_fifo import jfps_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    reserve,
    input  logic    push,
    input  result_t push_data,
    input  logic    pop,
    output logic    can_accept,
    output logic    out_valid,
    output result_t out_data
);

    localparam int unsigned PTR_W = $clog2(FIFO_DEPTH);
    localparam int unsigned CNT_W = $clog2(FIFO_DEPTH + 1);

    result_t            buf_reg [FIFO_DEPTH];
    logic [PTR_W:0]     wr_ptr_reg;
    logic [PTR_W:0]     rd_ptr_reg;
    logic [CNT_W-1:0]   credit_reg;
    logic [CNT_W-1:0]   credit_next;

    always_comb begin
        credit_next = credit_reg;
        if (reserve) begin
            credit_next = credit_next + CNT_W'(1);
        end
        if (pop) begin
            credit_next = credit_next - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + (PTR_W+1)'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + (PTR_W+1)'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            buf_reg[wr_ptr_reg[PTR_W-1:0]] <= push_data;
        end
    end

    assign can_accept = credit_reg < CNT_W'(FIFO_DEPTH);
    assign out_valid  = wr_ptr_reg != rd_ptr_reg;
    assign out_data   = buf_reg[rd_ptr_reg[PTR_W-1:0]];

endmodule

// ----- sv/jacobi_five_point_sweep_core.sv -----
// ----------------------------------------------------------------------------
// jacobi_five_point_sweep_core
// One Jacobi sweep of a 2-D grid with a five-point stencil, streamed.
// ----------------------------------------------------------------------------
// Usage:
//   Stream old potential and source values in raster order on the s_ channel,
//   one cell per transfer, boundary cells included. For every interior cell
//   the m_ channel carries one result transfer: the new value (a quarter of the
//   four neighbors plus the source, floored and saturated), its row and column,
//   the running maximum absolute change, and on the last interior cell the
//   sweep_end and converged flags. Boundary cells produce no transfer.
//   Throughput is one cell per cycle while s_ready is high, set by the
//   single-port-per-cycle line buffers; results pass the stencil stages first.
//   The output buffer holds 8 results; when the receiver stalls, results
//   collect there and s_ready drops once 8 are outstanding.
//   Write cfg_ registers (rows, columns, convergence limit) only while idle.
//   Reset returns the raster position, window and running maximum to zero and
//   the registers to their defaults; line buffers are not cleared.
// ----------------------------------------------------------------------------
module jacobi_five_point_sweep_core import jfps_pkg::*; #(
    parameter int unsigned MAX_COLS = DEF_MAX_COLS,
    parameter int unsigned MAX_ROWS = DEF_MAX_ROWS
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    // configuration writes
    input  logic                    cfg_wr_en,
    input  logic [IDX_W-1:0]        cfg_wr_index,
    input  logic [CFG_W-1:0]        cfg_wr_data,
    // input cells
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic signed [VAL_W-1:0] s_old_potential,
    input  logic signed [VAL_W-1:0] s_source_term,
    // results
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic signed [VAL_W-1:0] m_new_potential,
    output logic [COORD_W-1:0]      m_cell_row,
    output logic [COORD_W-1:0]      m_cell_col,
    output logic [LIMIT_W-1:0]      m_max_change,
    output logic                    m_sweep_end,
    output logic                    m_converged
);

    localparam int unsigned CW = $clog2(MAX_COLS);

    logic                    s_xfer;
    logic                    m_xfer;
    logic [CW-1:0]           col_addr;
    cell_tag_t               tag;
    logic [LIMIT_W-1:0]      limit;
    logic signed [VAL_W-1:0] top_q;
    logic signed [VAL_W-1:0] mid_q;
    logic signed [VAL_W-1:0] src_q;
    logic                    res_valid;
    result_t                 res;
    result_t                 out_data;
    logic                    can_accept;

    // an input transfer advances the scan, line buffers and stencil; an output transfer pops the buffer
    assign s_ready = can_accept;
    assign s_xfer  = s_valid && s_ready;
    assign m_xfer  = m_valid && m_ready;

    // raster position, sizes and limit
    jfps_scan #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_scan (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .advance      (s_xfer),
        .col_addr     (col_addr),
        .tag          (tag),
        .limit        (limit)
    );

    // two rows of potential and one of source, with read data registered on the transfer
    jfps_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (s_xfer),
        .addr    (col_addr),
        .pin     (s_old_potential),
        .sin     (s_source_term),
        .top_q   (top_q),
        .mid_q   (mid_q),
        .src_q   (src_q)
    );

    // three-stage arithmetic pipeline, never stalls
    jfps_stencil u_stencil (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (s_xfer),
        .pin       (s_old_potential),
        .tag       (tag),
        .top_q     (top_q),
        .mid_q     (mid_q),
        .src_q     (src_q),
        .limit     (limit),
        .res_valid (res_valid),
        .res       (res)
    );

    // hold results for a stalled receiver; reserve a slot per interior cell
    jfps_out_fifo u_out_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .reserve    (s_xfer && tag.emit),
        .push       (res_valid),
        .push_data  (res),
        .pop        (m_xfer),
        .can_accept (can_accept),
        .out_valid  (m_valid),
        .out_data   (out_data)
    );

    assign m_new_potential = out_data.new_potential;
    assign m_cell_row      = out_data.cell_row;
    assign m_cell_col      = out_data.cell_col;
    assign m_max_change    = out_data.max_change;
    assign m_sweep_end     = out_data.sweep_end;
    assign m_converged     = out_data.converged;

endmodule
